// File: hw/rtl/gfrs_pkg.sv
// ----------------------------------------------------------------------------
// gfrs_pkg
// Types and constants shared by the gear estimator cells and top level.
// ----------------------------------------------------------------------------
package gfrs_pkg;

   localparam int RPM_W      = 16;
   localparam int SPEED_W    = 10;
   localparam int CONST_W    = 32;
   localparam int RATIO_W    = 16;
   localparam int GEAR_W     = 3;
   localparam int PROD_W     = RPM_W + CONST_W;
   localparam int FRAC_DROP  = 12;
   localparam int QUOT_W     = PROD_W - FRAC_DROP;
   localparam int RATIO_SLOTS = 6;

   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FORMULA     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GEAR_COUNT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RATIO_FIRST = 3'd2;

   localparam logic [GEAR_W-1:0] GEAR_NONE          = 3'd0;
   localparam logic [GEAR_W-1:0] GEAR_COUNT_RESET   = 3'd6;

   // payload carried along the divider chain
   typedef struct packed {
      logic [QUOT_W-1:0]  word;      // dividend bits on top, quotient bits below
      logic [SPEED_W-1:0] rem;
      logic [SPEED_W-1:0] divisor;
      logic               stopped;
   } div_type;

   // payload carried along the gear compare chain
   typedef struct packed {
      logic [QUOT_W-1:0] quotient;
      logic [QUOT_W-1:0] best;
      logic [GEAR_W-1:0] gear;
      logic              stopped;
   } cmp_type;

endpackage

// File: hw/rtl/gfrs_div_cell.sv
// ----------------------------------------------------------------------------
// gfrs_div_cell
// One restoring-division step: shifts one dividend bit into the remainder and
// one quotient bit into the low end of the word.
// ----------------------------------------------------------------------------
module gfrs_div_cell
   import gfrs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  div_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output div_type out_data
);

   logic              valid_ff;
   div_type           data_ff;
   div_type           data_in;
   logic [SPEED_W:0]  trial;
   logic [SPEED_W:0]  diff;
   logic              fits;

   always_comb begin
      trial = {in_data.rem, in_data.word[QUOT_W-1]};
      fits  = trial >= {1'b0, in_data.divisor};
      diff  = trial - {1'b0, in_data.divisor};
      data_in         = in_data;
      data_in.word    = {in_data.word[QUOT_W-2:0], fits};
      data_in.rem     = fits ? diff[SPEED_W-1:0] : trial[SPEED_W-1:0];
   end

   // take a new transfer whenever this slot is empty or drains this cycle
   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// File: hw/rtl/gfrs_gear_cell.sv
// ----------------------------------------------------------------------------
// gfrs_gear_cell
// Compares the measured ratio against one gear ratio and keeps the nearest
// gear seen so far; ties keep the earlier, lower gear.
// ----------------------------------------------------------------------------
module gfrs_gear_cell
   import gfrs_pkg::*;
#(
   parameter int GEAR_INDEX = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [RATIO_W-1:0] gear_ratio,
   input  logic [GEAR_W-1:0]  gear_limit,
   input  logic               in_valid,
   output logic               in_ready,
   input  cmp_type            in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output cmp_type            out_data
);

   logic              valid_ff;
   cmp_type           data_ff;
   cmp_type           data_in;
   logic [QUOT_W-1:0] ratio_ext;
   logic [QUOT_W-1:0] delta;
   logic              active;
   logic              take;

   always_comb begin
      ratio_ext = {{(QUOT_W-RATIO_W){1'b0}}, gear_ratio};
      delta     = (in_data.quotient >= ratio_ext) ? in_data.quotient - ratio_ext
                                                  : ratio_ext - in_data.quotient;
      active    = !in_data.stopped && (GEAR_W'(GEAR_INDEX) < gear_limit);
      take      = active && ((in_data.gear == GEAR_NONE) || (delta < in_data.best));
      data_in   = in_data;
      if (take) begin
         data_in.best = delta;
         data_in.gear = GEAR_W'(GEAR_INDEX + 1);
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// File: hw/rtl/gear_from_rpm_and_speed.sv
// ----------------------------------------------------------------------------
// gear_from_rpm_and_speed
// Estimates the engaged gear from engine rpm and road speed: measured ratio
// = rpm * formula_constant / (speed * 4096), then the nearest configured gear.
//
//   channel  direction  fields (tdata / tuser)
//   req_     in         tdata: engine_rpm[15:0], road_speed[25:16]
//   rsp_     out        tdata: gear[2:0]
//   csr_     in         write enable, index 0..7, 32-bit data
//
// One sample per cycle sustained while rsp_tready stays high; stages: one
// multiply stage, one divider cell per quotient bit, one compare cell per gear.
// Every cell holds its own valid and ready, so bubbles close up and input is
// still taken while a finished result waits on rsp_tready.
// Reset clears all valid bits and returns the registers to their reset values.
// ----------------------------------------------------------------------------
module gear_from_rpm_and_speed
   import gfrs_pkg::*;
#(
   parameter int MAX_GEARS = 6
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // engine_rpm[15:0], road_speed[25:16]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // gear[2:0]
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   // configuration registers
   logic [CONST_W-1:0] formula_ff;
   logic [GEAR_W-1:0]  gear_count_ff;
   logic [RATIO_W-1:0] ratio_ff [RATIO_SLOTS];
   logic [GEAR_W-1:0]  gear_limit;

   always_ff @(posedge clock) begin
      if (reset) begin
         formula_ff    <= '0;
         gear_count_ff <= GEAR_COUNT_RESET;
         for (int i = 0; i < RATIO_SLOTS; i++) begin
            ratio_ff[i] <= '0;
         end
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_FORMULA:    formula_ff    <= csr_wr_data;
            CSR_GEAR_COUNT: gear_count_ff <= csr_wr_data[GEAR_W-1:0];
            default: begin
               for (int i = 0; i < RATIO_SLOTS; i++) begin
                  if (csr_index == CSR_RATIO_FIRST + CSR_IDX_W'(i)) begin
                     ratio_ff[i] <= csr_wr_data[RATIO_W-1:0];
                  end
               end
            end
         endcase
      end
   end

   // saturate the count to the number of compare cells
   assign gear_limit = (gear_count_ff > GEAR_W'(MAX_GEARS)) ? GEAR_W'(MAX_GEARS)
                                                            : gear_count_ff;

   // multiply stage
   logic [RPM_W-1:0]   rpm;
   logic [SPEED_W-1:0] speed;
   logic [PROD_W-1:0]  product;
   logic               mul_valid_ff;
   div_type            mul_ff;
   div_type            mul_in;
   logic               mul_ready;

   assign rpm     = req_tdata[RPM_W-1:0];
   assign speed   = req_tdata[RPM_W +: SPEED_W];
   assign product = PROD_W'(rpm) * PROD_W'(formula_ff);

   always_comb begin
      mul_in.word    = product[PROD_W-1:FRAC_DROP];
      mul_in.rem     = '0;
      mul_in.divisor = speed;
      mul_in.stopped = (speed == '0);
   end

   assign req_tready = !mul_valid_ff || mul_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
      end else if (req_tready) begin
         mul_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready) begin
         mul_ff <= mul_in;
      end
   end

   // divider chain, one quotient bit per cell
   logic    div_valid [QUOT_W+1];
   logic    div_ready [QUOT_W+1];
   div_type div_data  [QUOT_W+1];

   assign div_valid[0] = mul_valid_ff;
   assign div_data[0]  = mul_ff;
   assign mul_ready    = div_ready[0];

   for (genvar k = 0; k < QUOT_W; k++) begin : g_div
      gfrs_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (div_valid[k]),
         .in_ready  (div_ready[k]),
         .in_data   (div_data[k]),
         .out_valid (div_valid[k+1]),
         .out_ready (div_ready[k+1]),
         .out_data  (div_data[k+1])
      );
   end

   // gear compare chain
   logic    cmp_valid [MAX_GEARS+1];
   logic    cmp_ready [MAX_GEARS+1];
   cmp_type cmp_data  [MAX_GEARS+1];

   always_comb begin
      cmp_data[0].quotient = div_data[QUOT_W].word;
      cmp_data[0].best     = '0;
      cmp_data[0].gear     = GEAR_NONE;
      cmp_data[0].stopped  = div_data[QUOT_W].stopped;
   end

   assign cmp_valid[0]      = div_valid[QUOT_W];
   assign div_ready[QUOT_W] = cmp_ready[0];

   for (genvar g = 0; g < MAX_GEARS; g++) begin : g_gear
      gfrs_gear_cell #(
         .GEAR_INDEX (g)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .gear_ratio (ratio_ff[g]),
         .gear_limit (gear_limit),
         .in_valid   (cmp_valid[g]),
         .in_ready   (cmp_ready[g]),
         .in_data    (cmp_data[g]),
         .out_valid  (cmp_valid[g+1]),
         .out_ready  (cmp_ready[g+1]),
         .out_data   (cmp_data[g+1])
      );
   end

   assign rsp_tvalid           = cmp_valid[MAX_GEARS];
   assign cmp_ready[MAX_GEARS] = rsp_tready;
   assign rsp_tdata = {{(RSP_DATA_W-GEAR_W){1'b0}}, cmp_data[MAX_GEARS].gear};

endmodule

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for gear_from_rpm_and_speed. Samples go in on req_ and
// each transfer is paired with the gear predicted from the current register
// settings. Every rsp_ transfer is checked in order against that prediction.
// Register settings change only while the pipeline is empty. They cover the
// extremes, ties between gears and a saturated gear count. Most random samples
// are aimed near a configured ratio or a midpoint between two ratios.
// ----------------------------------------------------------------------------
module testbench;
   import gfrs_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int GEAR_LIMIT = 6;
   localparam int BURST_MAX  = 18;

   typedef struct packed {
      logic [SPEED_W-1:0] speed;
      logic [RPM_W-1:0]   rpm;
   } sample_t;

   logic                  clock;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_wr_en   = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index   = '0;
   logic [CSR_DATA_W-1:0] csr_wr_data = '0;

   // register copy used for prediction
   logic [CONST_W-1:0] cfg_formula;
   logic [GEAR_W-1:0]  cfg_gear_count;
   logic [RATIO_W-1:0] cfg_ratio [RATIO_SLOTS];

   sample_t           sample_queue [$];
   logic [GEAR_W-1:0] gear_due [$];
   int                mismatch_count = 0;
   int                result_count   = 0;
   int                idle_odds      = 0;
   int                send_gap       = 0;
   int                stall_left     = 0;
   logic              req_taken      = 1'b0;

   gear_from_rpm_and_speed #(
      .MAX_GEARS (GEAR_LIMIT)
   ) uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [GEAR_W-1:0] nearest_gear(sample_t s);
      logic [63:0]       measured;
      logic [63:0]       delta;
      logic [63:0]       best;
      logic [GEAR_W-1:0] gear;
      int                used;
      used = (cfg_gear_count > GEAR_LIMIT) ? GEAR_LIMIT : int'(cfg_gear_count);
      gear = GEAR_NONE;
      best = '0;
      if (s.speed != '0 && used != 0) begin
         measured = (64'(s.rpm) * 64'(cfg_formula)) / (64'(s.speed) << FRAC_DROP);
         for (int g = 0; g < used; g++) begin
            delta = (measured >= 64'(cfg_ratio[g])) ? measured - 64'(cfg_ratio[g])
                                                    : 64'(cfg_ratio[g]) - measured;
            // strictly smaller only, so ties stay with the lower gear
            if (g == 0 || delta < best) begin
               best = delta;
               gear = GEAR_W'(g + 1);
            end
         end
      end
      return gear;
   endfunction

   task automatic report_mismatch(string msg);
      $display("[%0t] result %0d: %s", $realtime, result_count, msg);
      mismatch_count++;
   endtask

   // sender: hold the current item until its transfer, then advance
   always @(negedge clock) begin
      if (!req_tvalid || req_taken) begin
         if (send_gap > 0) begin
            req_tvalid <= 1'b0;
            send_gap--;
         end else if (sample_queue.size() != 0) begin
            req_tdata  <= {{(REQ_DATA_W - $bits(sample_t)){1'b0}}, sample_queue.pop_front()};
            req_tvalid <= 1'b1;
            if (idle_odds != 0 && $urandom_range(idle_odds - 1) == 0)
               send_gap = $urandom_range(1, BURST_MAX);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver: stall in bursts
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else begin
         rsp_tready <= 1'b1;
         if (idle_odds != 0 && $urandom_range(idle_odds - 1) == 0)
            stall_left = $urandom_range(1, BURST_MAX);
      end
   end

   always @(posedge clock) begin
      logic [GEAR_W-1:0] want;
      logic [GEAR_W-1:0] got;
      req_taken <= !reset && req_tvalid && req_tready;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[GEAR_W-1:0];
            if (gear_due.size() == 0) begin
               report_mismatch($sformatf("gear %0d with no sample waiting", got));
            end else begin
               want = gear_due.pop_front();
               if (got !== want)
                  report_mismatch($sformatf("gear got %0d, want %0d", got, want));
            end
            result_count++;
         end
         if (req_tvalid && req_tready)
            gear_due.push_back(nearest_gear(sample_t'(req_tdata[$bits(sample_t)-1:0])));
      end
   end

   task automatic set_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
      case (idx)
         CSR_FORMULA:    cfg_formula    = value;
         CSR_GEAR_COUNT: cfg_gear_count = value[GEAR_W-1:0];
         default:        cfg_ratio[idx - CSR_RATIO_FIRST] = value[RATIO_W-1:0];
      endcase
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic add_sample(logic [RPM_W-1:0] rpm, logic [SPEED_W-1:0] speed);
      sample_t s;
      s.rpm   = rpm;
      s.speed = speed;
      sample_queue.push_back(s);
   endtask

   // wait until every sample has gone through and every gear has come back;
   // check at the rising edge, where the sender's outputs are settled
   task automatic drain();
      while (sample_queue.size() != 0 || req_tvalid || gear_due.size() != 0)
         @(posedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic load_settings();
      logic [CSR_DATA_W-1:0] value;
      logic [CSR_DATA_W-1:0] prev;
      int                    base;
      case ($urandom_range(7))
         0:       value = '0;
         1:       value = '1;
         2:       value = $urandom;
         default: value = $urandom_range(32'h0100_0000, 32'h0004_0000);
      endcase
      set_reg(CSR_FORMULA, value);
      value = ($urandom_range(2) == 0) ? CSR_DATA_W'(GEAR_COUNT_RESET) : $urandom;
      set_reg(CSR_GEAR_COUNT, value);
      base = $urandom_range(8000, 20000);
      prev = '0;
      for (int g = 0; g < RATIO_SLOTS; g++) begin
         case ($urandom_range(9))
            0:       value = '0;
            1:       value = 32'h0000_FFFF;
            2:       value = prev;                 // duplicate ratio forces a tie
            3:       value = $urandom;
            default: value = CSR_DATA_W'(base);
         endcase
         set_reg(CSR_RATIO_FIRST + CSR_IDX_W'(g), value);
         prev = value;
         base = base * $urandom_range(60, 85) / 100;
      end
   endtask

   // aim the measured ratio at a configured gear, a nearby value or a midpoint
   task automatic add_aimed_sample();
      logic [63:0]        target;
      logic [63:0]        scaled;
      logic [63:0]        rpm_fit;
      logic [SPEED_W-1:0] speed;
      int                 g;
      g = $urandom_range(RATIO_SLOTS - 1);
      target = 64'(cfg_ratio[g]);
      case ($urandom_range(3))
         0: target = (target + 64'(cfg_ratio[(g + 1) % RATIO_SLOTS])) / 2;
         1: target = target + $urandom_range(64);
         2: if (target > 64) target = target - $urandom_range(64);
         default: ;
      endcase
      speed = ($urandom_range(19) == 0) ? '0
                                        : SPEED_W'($urandom_range(1, $urandom_range(1, 1023)));
      scaled  = (target * 64'(speed)) << FRAC_DROP;
      rpm_fit = (cfg_formula != '0) ? (scaled + 64'(cfg_formula) / 2) / 64'(cfg_formula)
                                    : 64'hFFFF_FFFF;
      if (rpm_fit <= 64'(16'hFFFF) && $urandom_range(3) != 0)
         add_sample(RPM_W'(rpm_fit), speed);
      else
         add_sample(RPM_W'($urandom), speed);
   endtask

   initial begin
      cfg_formula    = '0;
      cfg_gear_count = GEAR_COUNT_RESET;
      foreach (cfg_ratio[g]) cfg_ratio[g] = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: measured ratio is always zero
      add_sample(16'h0000, 10'h000);
      add_sample(16'hFFFF, 10'h3FF);
      add_sample(16'hAAAA, 10'h155);
      add_sample(16'h5555, 10'h2AA);
      add_sample(16'd100, 10'h000);
      drain();

      // formula constant of 4096 makes the measured ratio rpm / speed
      set_reg(CSR_FORMULA, 32'd4096);
      set_reg(CSR_GEAR_COUNT, 32'd3);
      set_reg(CSR_RATIO_FIRST + 3'd0, 32'd100);
      set_reg(CSR_RATIO_FIRST + 3'd1, 32'd200);
      set_reg(CSR_RATIO_FIRST + 3'd2, 32'd300);
      set_reg(CSR_RATIO_FIRST + 3'd3, 32'h0000_FFFF);
      set_reg(CSR_RATIO_FIRST + 3'd4, 32'h0000_FFFF);
      set_reg(CSR_RATIO_FIRST + 3'd5, 32'h0000_FFFF);
      add_sample(16'd150, 10'd1);
      add_sample(16'd250, 10'd1);
      add_sample(16'd251, 10'd1);
      add_sample(16'd0, 10'd1);
      add_sample(16'hFFFF, 10'd1);
      add_sample(16'd600, 10'd2);
      add_sample(16'd300, 10'd0);
      drain();

      // largest constant, gear count above the limit
      set_reg(CSR_FORMULA, 32'hFFFF_FFFF);
      set_reg(CSR_GEAR_COUNT, 32'd7);
      for (int g = 0; g < RATIO_SLOTS - 1; g++)
         set_reg(CSR_RATIO_FIRST + CSR_IDX_W'(g), 32'(g + 1));
      set_reg(CSR_RATIO_FIRST + 3'd5, 32'h0000_FFFF);
      add_sample(16'hFFFF, 10'd1);
      add_sample(16'd1, 10'h3FF);
      add_sample(16'd0, 10'd5);
      drain();

      set_reg(CSR_GEAR_COUNT, 32'd0);
      add_sample(16'd1000, 10'd50);
      add_sample(16'hFFFF, 10'd1);
      drain();

      for (int phase = 0; phase < 8; phase++) begin
         load_settings();
         case ($urandom_range(3))
            0:       idle_odds = 0;
            1:       idle_odds = 2;
            2:       idle_odds = 6;
            default: idle_odds = 16;
         endcase
         if (phase == 7) idle_odds = 0;
         for (int n = 0; n < 100; n++) begin
            if ($urandom_range(4) == 0)
               add_sample(RPM_W'($urandom), SPEED_W'($urandom));
            else
               add_aimed_sample();
         end
         drain();
      end

      repeat (50) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
